>>> design/spectral_index_colorizer_macros.svh
// Assertion macros shared by the checker of the spectral index colorizer.
`ifndef SPECTRAL_INDEX_COLORIZER_MACROS_SVH
`define SPECTRAL_INDEX_COLORIZER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked during reset.
`define SIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also covers the reset cycles.
`define SIC_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset implication");

`endif

>>> design/sic_pkg.sv
`default_nettype none

package sic_pkg;

  localparam int SAMPLE_BITS          = 16;
  localparam int SAMPLE_FRACTION_BITS = 12;
  localparam int INDEX_FRACTION_BITS  = 14;

  localparam int FIELD_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam int SB  = SAMPLE_BITS;
  localparam int SFB = SAMPLE_FRACTION_BITS;
  localparam int IFB = INDEX_FRACTION_BITS;

  // difference a-b, signed
  localparam int D_W    = SB + 1;
  // multiplier factor: one+L, 5 or 1, unsigned
  localparam int FACT_W = ((SFB > CFG_W) ? SFB : CFG_W) + 2;
  // numerator, signed
  localparam int NUM_W  = D_W + FACT_W + 1;
  // denominator, signed
  localparam int DEN_W  = SB + SFB + 6;
  localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  // signed index word before output sizing
  localparam int Q_W    = IFB + 2;

  typedef enum logic [1:0] {
    KIND_ND   = 2'd0,
    KIND_SAVI = 2'd1,
    KIND_EVI  = 2'd2,
    KIND_RSVD = 2'd3
  } index_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDEX_KIND    = 3'd0,
    REG_SOIL_OFFSET   = 3'd1,
    REG_NODATA_ENABLE = 3'd2,
    REG_NODATA_FIRST  = 3'd3,
    REG_NODATA_SECOND = 3'd4,
    REG_NODATA_THIRD  = 3'd5,
    REG_OPAQUE        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] first_sample;
    logic [FIELD_W-1:0] second_sample;
    logic [FIELD_W-1:0] third_sample;
    logic [2:0]         sample_nan_flags;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [7:0]                alpha;
    logic signed [FIELD_W-1:0] index_value;
    logic                      index_valid;
  } pixel_out_t;

  // one divider stage: partial remainder, quotient bits so far, sideband
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] ad;
    logic [IFB-1:0]   q;
    logic             neg;
    logic             sat;
    logic             bad;
  } div_t;

endpackage

`default_nettype wire

>>> design/spectral_index_colorizer.sv
`default_nettype none

// Spectral index colorizer. Takes one pixel (three unsigned band samples with
// 12 fraction bits plus NaN flags) per beat and returns one RGBA pixel with
// the saturated index value. The block is a single pipeline of 19 register
// stages (5 plus one per quotient bit): it accepts a pixel every cycle when
// the output side keeps up. The restoring divider computes one quotient bit
// per stage. Every stage carries a valid bit and stalls only when the stage
// after it is full and held, so bubbles collapse and a waiting result does
// not stop intake until the pipeline fills. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once; write them only while the
// pipeline is empty. Nodata, NaN, a zero denominator or the reserved index
// kind give transparent black (white with alpha 255 when opaque background
// is set) with index_valid low.
module spectral_index_colorizer (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             pixel_valid,
  output logic                            pixel_ready,
  input  wire sic_pkg::pixel_in_t         pixel,
  output logic                            color_valid,
  input  wire                             color_ready,
  output sic_pkg::pixel_out_t             color,
  input  wire                             cfg_we,
  input  wire [sic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [sic_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SB     = sic_pkg::SB;
  localparam int SFB    = sic_pkg::SFB;
  localparam int IFB    = sic_pkg::IFB;
  localparam int D_W    = sic_pkg::D_W;
  localparam int FACT_W = sic_pkg::FACT_W;
  localparam int NUM_W  = sic_pkg::NUM_W;
  localparam int DEN_W  = sic_pkg::DEN_W;
  localparam int CMP_W  = sic_pkg::CMP_W;
  localparam int Q_W    = sic_pkg::Q_W;
  localparam int CFG_W  = sic_pkg::CFG_W;

  localparam logic signed [DEN_W-1:0] TWO_ONE  = DEN_W'(1) << (SFB + 1);
  localparam logic [FACT_W-1:0]       FACT_ONE = FACT_W'(1) << SFB;
  localparam logic [Q_W-1:0]          Q_ONE    = Q_W'(1) << IFB;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  sic_pkg::index_kind_t index_kind;
  logic [CFG_W-1:0]     soil_offset;
  logic [2:0]           nodata_enable;
  logic [CFG_W-1:0]     nodata_first;
  logic [CFG_W-1:0]     nodata_second;
  logic [CFG_W-1:0]     nodata_third;
  logic                 opaque_background;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_kind        <= sic_pkg::KIND_ND;
      soil_offset       <= CFG_W'(2048);
      nodata_enable     <= '0;
      nodata_first      <= '0;
      nodata_second     <= '0;
      nodata_third      <= '0;
      opaque_background <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sic_pkg::REG_INDEX_KIND:    index_kind <= sic_pkg::index_kind_t'(cfg_data[1:0]);
        sic_pkg::REG_SOIL_OFFSET:   soil_offset <= cfg_data;
        sic_pkg::REG_NODATA_ENABLE: nodata_enable <= cfg_data[2:0];
        sic_pkg::REG_NODATA_FIRST:  nodata_first <= cfg_data;
        sic_pkg::REG_NODATA_SECOND: nodata_second <= cfg_data;
        sic_pkg::REG_NODATA_THIRD:  nodata_third <= cfg_data;
        sic_pkg::REG_OPAQUE:        opaque_background <= cfg_data[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stall chain: a stage loads when it is empty or the next stage loads.
  // ---------------------------------------------------------------------------
  logic fr_v, mul_v, abs_v, sgn_v;
  logic fr_en, mul_en, abs_en, sgn_en, out_en;
  logic div_v  [IFB];
  logic div_en [IFB];

  assign out_en = !color_valid || color_ready;
  assign sgn_en = !sgn_v || out_en;
  assign div_en[IFB-1] = !div_v[IFB-1] || sgn_en;
  for (genvar k = 0; k < IFB - 1; k++) begin : g_en
    assign div_en[k] = !div_v[k] || div_en[k+1];
  end
  assign abs_en = !abs_v || div_en[0];
  assign mul_en = !mul_v || abs_en;
  assign fr_en  = !fr_v || mul_en;
  assign pixel_ready = fr_en;

  // ---------------------------------------------------------------------------
  // Front stage: validity checks, difference, factor and denominator
  // ---------------------------------------------------------------------------
  logic [SB-1:0]            s1, s2, s3;
  logic signed [DEN_W-1:0]  s1e, s2e, s3e, le;
  logic signed [DEN_W-1:0]  den_c;
  logic [FACT_W-1:0]        fact_c;
  logic                     bad_c;

  assign s1 = pixel.first_sample[SB-1:0];
  assign s2 = pixel.second_sample[SB-1:0];
  assign s3 = pixel.third_sample[SB-1:0];
  assign s1e = $signed(DEN_W'(s1));
  assign s2e = $signed(DEN_W'(s2));
  assign s3e = $signed(DEN_W'(s3));
  assign le  = $signed(DEN_W'(soil_offset));

  always_comb begin
    bad_c = (index_kind == sic_pkg::KIND_RSVD)
         || pixel.sample_nan_flags[0]
         || pixel.sample_nan_flags[1]
         || (nodata_enable[0] && (s1 == nodata_first[SB-1:0]))
         || (nodata_enable[1] && (s2 == nodata_second[SB-1:0]))
         || ((index_kind == sic_pkg::KIND_EVI)
             && (pixel.sample_nan_flags[2]
                 || (nodata_enable[2] && (s3 == nodata_third[SB-1:0]))));
    unique case (index_kind)
      sic_pkg::KIND_SAVI: begin
        fact_c = FACT_ONE + FACT_W'(soil_offset);
        den_c  = (s1e + s2e + le) <<< SFB;
      end
      sic_pkg::KIND_EVI: begin
        // doubled: 2a + 12b - 15c + 2
        fact_c = FACT_W'(5);
        den_c  = (s1e <<< 1) + (s2e <<< 3) + (s2e <<< 2)
               - ((s3e <<< 4) - s3e) + TWO_ONE;
      end
      default: begin
        fact_c = FACT_W'(1);
        den_c  = s1e + s2e;
      end
    endcase
  end

  logic signed [D_W-1:0]   fr_d;
  logic [FACT_W-1:0]       fr_fact;
  logic signed [DEN_W-1:0] fr_den;
  logic                    fr_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_v <= 1'b0;
    end else if (fr_en) begin
      fr_v <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_en) begin
      fr_d    <= $signed({1'b0, s1}) - $signed({1'b0, s2});
      fr_fact <= fact_c;
      fr_den  <= den_c;
      fr_bad  <= bad_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: numerator
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] mul_p;
  logic signed [NUM_W-1:0] mul_num;
  logic signed [DEN_W-1:0] mul_den;
  logic                    mul_bad;

  // widen both operands so the product keeps every bit
  assign mul_p = NUM_W'(fr_d) * NUM_W'($signed({1'b0, fr_fact}));

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (mul_en) begin
      mul_v <= fr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_num <= mul_p;
      mul_den <= fr_den;
      mul_bad <= fr_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Magnitude stage: signs, zero denominator, saturation
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] an_c;
  logic [DEN_W-1:0] ad_c;
  logic             sat_c;

  assign an_c  = mul_num[NUM_W-1] ? NUM_W'(-mul_num) : NUM_W'(mul_num);
  assign ad_c  = mul_den[DEN_W-1] ? DEN_W'(-mul_den) : DEN_W'(mul_den);
  assign sat_c = CMP_W'(an_c) >= CMP_W'(ad_c);

  sic_pkg::div_t abs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_v <= 1'b0;
    end else if (abs_en) begin
      abs_v <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (abs_en) begin
      // below the denominator the numerator fits the remainder width
      abs_q.rem <= sat_c ? '0 : an_c[DEN_W-1:0];
      abs_q.ad  <= ad_c;
      abs_q.q   <= '0;
      abs_q.neg <= mul_num[NUM_W-1] != mul_den[DEN_W-1];
      abs_q.sat <= sat_c;
      abs_q.bad <= mul_bad || (mul_den == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage
  // ---------------------------------------------------------------------------
  sic_pkg::div_t div_q [IFB];

  function automatic sic_pkg::div_t div_step(sic_pkg::div_t s);
    sic_pkg::div_t  o;
    logic [DEN_W:0] r2;
    logic           ge;
    o  = s;
    r2 = {s.rem, 1'b0};
    ge = r2 >= {1'b0, s.ad};
    o.rem = ge ? DEN_W'(r2 - {1'b0, s.ad}) : DEN_W'(r2);
    o.q   = {s.q[IFB-2:0], ge};
    return o;
  endfunction

  for (genvar k = 0; k < IFB; k++) begin : g_div
    sic_pkg::div_t prev;
    logic          prev_v;
    if (k == 0) begin : g_first
      assign prev   = abs_q;
      assign prev_v = abs_v;
    end else begin : g_next
      assign prev   = div_q[k-1];
      assign prev_v = div_v[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[k] <= 1'b0;
      end else if (div_en[k]) begin
        div_v[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (div_en[k]) begin
        div_q[k] <= div_step(prev);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sign stage: apply sign and saturation, zero the index of invalid pixels
  // ---------------------------------------------------------------------------
  sic_pkg::div_t          dl;
  logic [Q_W-1:0]         mag_c;
  logic signed [Q_W-1:0]  qs_c;

  assign dl    = div_q[IFB-1];
  assign mag_c = dl.sat ? Q_ONE : Q_W'(dl.q);
  assign qs_c  = dl.bad ? '0 : (dl.neg ? $signed(-mag_c) : $signed(mag_c));

  logic signed [Q_W-1:0] sgn_q;
  logic                  sgn_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      sgn_v <= 1'b0;
    end else if (sgn_en) begin
      sgn_v <= div_v[IFB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sgn_en) begin
      sgn_q  <= qs_c;
      sgn_ok <= !dl.bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Color stage: red-yellow-green ramp, background compositing, output beat
  // ---------------------------------------------------------------------------
  logic [IFB:0]   t_c;
  logic [IFB+8:0] ramp_c;
  logic [7:0]     lvl_c;
  sic_pkg::pixel_out_t color_next;

  assign t_c    = sgn_q[Q_W-1] ? (IFB+1)'(sgn_q + $signed(Q_ONE))
                               : (IFB+1)'($signed(Q_ONE) - sgn_q);
  // times 255 as shift and subtract
  assign ramp_c = ((IFB+9)'(t_c) << 8) - (IFB+9)'(t_c);
  assign lvl_c  = ramp_c[IFB+7:IFB];

  always_comb begin
    color_next.index_value = sic_pkg::FIELD_W'(sgn_q);
    color_next.index_valid = sgn_ok;
    if (sgn_ok) begin
      color_next.red   = sgn_q[Q_W-1] ? 8'd255 : lvl_c;
      color_next.green = sgn_q[Q_W-1] ? lvl_c : 8'd255;
      color_next.blue  = 8'd0;
      color_next.alpha = 8'd255;
    end else begin
      color_next.red   = opaque_background ? 8'd255 : 8'd0;
      color_next.green = opaque_background ? 8'd255 : 8'd0;
      color_next.blue  = opaque_background ? 8'd255 : 8'd0;
      color_next.alpha = opaque_background ? 8'd255 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (out_en) begin
      color_valid <= sgn_v;
    end
  end

  // hold the beat while the consumer stalls
  always_ff @(posedge clk) begin
    if (out_en) begin
      color <= color_next;
    end
  end

endmodule

`default_nettype wire

>>> design/sic_checker.sv
`default_nettype none

`include "spectral_index_colorizer_macros.svh"

module sic_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          pixel_valid,
  input wire                          pixel_ready,
  input wire sic_pkg::pixel_in_t      pixel,
  input wire                          color_valid,
  input wire                          color_ready,
  input wire sic_pkg::pixel_out_t     color,
  input wire                          cfg_we,
  input wire [sic_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire [sic_pkg::CFG_W-1:0]     cfg_data
);

  logic unused_ok;
  assign unused_ok = pixel_valid ^ pixel_ready ^ (^pixel) ^ cfg_we ^ (^cfg_index)
                   ^ (^cfg_data);

  // a stalled result beat holds
  `SIC_ASSERT_NEXT(a_out_hold, color_valid && !color_ready,
                   color_valid && $stable(color))

  // invalid pixels carry a zero index and a uniform gray level
  `SIC_ASSERT_NOW(a_invalid_flat, color_valid && !color.index_valid,
                  color.index_value == 0 && color.red == color.green
                  && color.green == color.blue)

  // valid pixels are opaque, have no blue and one full ramp channel
  `SIC_ASSERT_NOW(a_valid_ramp, color_valid && color.index_valid,
                  color.blue == 8'd0 && color.alpha == 8'd255
                  && (color.red == 8'd255 || color.green == 8'd255))

  // reset empties the pipeline
  `SIC_ASSERT_NEXT_RST(a_reset_empty, rst, !color_valid)

endmodule

bind spectral_index_colorizer sic_checker u_sic_checker (.*);

`default_nettype wire
